FILE: sv/quaternion_product_rotator_assert.svh
// Assertion macros used by the checker file.
`ifndef QUATERNION_PRODUCT_ROTATOR_ASSERT_SVH
`define QUATERNION_PRODUCT_ROTATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define QPR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion unit check failed");

// Implication over a fixed number of cycles, disabled while reset is high.
`define QPR_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("quaternion unit timing check failed");

`endif

FILE: sv/qpr_pkg.sv
package qpr_pkg;

  // Default component format: Q2.14
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // Edge at which a word is accepted to edge at which its result is taken
  localparam int LATENCY = 7;

  typedef enum logic [1:0] {
    OP_PRODUCT = 2'd0,
    OP_ROTATE  = 2'd1,
    OP_CONJ    = 2'd2
  } op_t;

  // Control that travels with each word down the pipe
  typedef struct packed {
    logic       vld;
    logic [1:0] op;
  } ctrl_t;

  // Hamilton product: component k, term i is a[i] * b[k ^ i];
  // bit i set means that term enters with a minus sign.
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

FILE: sv/qpr_mult.sv
// One register stage: the sixteen signed terms of a Hamilton product.
module qpr_mult #(
  parameter int DATA_WIDTH = qpr_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  qpr_pkg::ctrl_t                   in_ctrl,
  input  logic signed [DATA_WIDTH:0]       qa [4],
  input  logic signed [DATA_WIDTH:0]       qb [4],
  output qpr_pkg::ctrl_t                   out_ctrl,
  output logic signed [2*DATA_WIDTH+1:0]   prod [4][4]
);

  localparam int PW = 2 * DATA_WIDTH + 2;

  logic signed [PW-1:0] mul [4][4];

  // Raw products, operand b picked by the Hamilton index pattern
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        mul[k][i] = qa[i] * qb[k ^ i];
      end
    end
  end

  // Apply term signs and register
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        prod[k][i] <= qpr_pkg::HAM_NEG[k][i] ? -mul[k][i] : mul[k][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else begin
      out_ctrl <= in_ctrl;
    end
  end

endmodule

FILE: sv/qpr_accum.sv
// Two register stages: pairwise sums with the rounding half folded in,
// then final sum, shift, and saturation to the component width.
module qpr_accum #(
  parameter int DATA_WIDTH = qpr_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  qpr_pkg::ctrl_t                  in_ctrl,
  input  logic signed [2*DATA_WIDTH+1:0]  prod [4][4],
  output qpr_pkg::ctrl_t                  out_ctrl,
  output logic signed [DATA_WIDTH-1:0]    res [4],
  output logic                            sat
);

  localparam int PW = 2 * DATA_WIDTH + 2;
  localparam int SW = PW + 2;
  localparam logic signed [PW:0]   HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAXV = {{(SW - DATA_WIDTH + 1){1'b0}},
                                           {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW - DATA_WIDTH + 1){1'b1}},
                                           {(DATA_WIDTH - 1){1'b0}}};

  qpr_pkg::ctrl_t        ctrl_a;
  logic signed [PW:0]    pair [4][2];
  logic signed [SW-1:0]  sum  [4];
  logic signed [SW-1:0]  rnd  [4];
  logic                  hi   [4];
  logic                  lo   [4];

  // Stage A: two partial sums per component
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pair[k][0] <= prod[k][0] + prod[k][1] + HALF;
      pair[k][1] <= prod[k][2] + prod[k][3];
    end
  end

  // Stage B: full sum, floor shift, range check
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = pair[k][0] + pair[k][1];
      rnd[k] = sum[k] >>> FRAC_BITS;
      hi[k]  = rnd[k] > MAXV;
      lo[k]  = rnd[k] < MINV;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (hi[k]) begin
        res[k] <= MAXV[DATA_WIDTH-1:0];
      end else if (lo[k]) begin
        res[k] <= MINV[DATA_WIDTH-1:0];
      end else begin
        res[k] <= rnd[k][DATA_WIDTH-1:0];
      end
    end
    sat <= hi[0] | lo[0] | hi[1] | lo[1] | hi[2] | lo[2] | hi[3] | lo[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a   <= '0;
      out_ctrl <= '0;
    end else begin
      ctrl_a   <= in_ctrl;
      out_ctrl <= ctrl_a;
    end
  end

endmodule

FILE: sv/quaternion_product_rotator.sv
// Channel   Handshake           Fields
// -------   -----------------   ----------------------------------------------
// input     start / busy        opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
// result    done (one cycle)    r_w, r_x, r_y, r_z, saturated
//
// One word accepted per cycle, sustained. Seven register stages (two
// multiplier stages, two two-stage adder trees, the output register) lie
// between the accepting edge and done, which rises together with the result.
// busy follows rst: no word is taken while reset is high, and reset drops
// every word in flight. The result side cannot stall, so neither does the pipe.
module quaternion_product_rotator #(
  parameter int DATA_WIDTH = qpr_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic signed [DATA_WIDTH-1:0]  a_w,
  input  logic signed [DATA_WIDTH-1:0]  a_x,
  input  logic signed [DATA_WIDTH-1:0]  a_y,
  input  logic signed [DATA_WIDTH-1:0]  a_z,
  input  logic signed [DATA_WIDTH-1:0]  b_w,
  input  logic signed [DATA_WIDTH-1:0]  b_x,
  input  logic signed [DATA_WIDTH-1:0]  b_y,
  input  logic signed [DATA_WIDTH-1:0]  b_z,
  output logic                          done,
  output logic signed [DATA_WIDTH-1:0]  r_w,
  output logic signed [DATA_WIDTH-1:0]  r_x,
  output logic signed [DATA_WIDTH-1:0]  r_y,
  output logic signed [DATA_WIDTH-1:0]  r_z,
  output logic                          saturated
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH + 2;
  localparam logic signed [DW-1:0] MAXD = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0] MIND = {1'b1, {(DW - 1){1'b0}}};

  qpr_pkg::ctrl_t        in_ctrl;
  qpr_pkg::ctrl_t        c1;
  qpr_pkg::ctrl_t        c3;
  qpr_pkg::ctrl_t        c4;
  qpr_pkg::ctrl_t        c6;
  logic signed [DW:0]    qa1 [4];
  logic signed [DW:0]    qb1 [4];
  logic signed [DW:0]    qa2 [4];
  logic signed [DW:0]    qb2 [4];
  logic signed [PW-1:0]  prod1 [4][4];
  logic signed [PW-1:0]  prod2 [4][4];
  logic signed [DW-1:0]  t  [4];
  logic signed [DW-1:0]  r2 [4];
  logic                  f1;
  logic                  f2;
  logic signed [DW-1:0]  a_d [3][4];
  logic signed [DW-1:0]  conj [4];
  logic                  conj_sat;
  logic signed [DW-1:0]  s_t    [3][4];
  logic                  s_f1   [3];
  logic signed [DW-1:0]  s_conj [3][4];
  logic                  s_cf   [3];
  logic signed [DW-1:0]  sel [4];
  logic                  sel_sat;

  assign busy = rst;

  // Input word, first product operands; rotation uses a*(0,v)
  always_comb begin
    in_ctrl.vld = start & ~busy;
    in_ctrl.op  = opcode;
    qa1[0] = {a_w[DW-1], a_w};
    qa1[1] = {a_x[DW-1], a_x};
    qa1[2] = {a_y[DW-1], a_y};
    qa1[3] = {a_z[DW-1], a_z};
    qb1[0] = (opcode == qpr_pkg::OP_ROTATE) ? '0 : {b_w[DW-1], b_w};
    qb1[1] = {b_x[DW-1], b_x};
    qb1[2] = {b_y[DW-1], b_y};
    qb1[3] = {b_z[DW-1], b_z};
  end

  qpr_mult #(.DATA_WIDTH(DATA_WIDTH)) u_mult1 (
    .clk(clk), .rst(rst), .in_ctrl(in_ctrl), .qa(qa1), .qb(qb1),
    .out_ctrl(c1), .prod(prod1)
  );

  qpr_accum #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_acc1 (
    .clk(clk), .rst(rst), .in_ctrl(c1), .prod(prod1),
    .out_ctrl(c3), .res(t), .sat(f1)
  );

  // Carry a alongside the first product
  always_ff @(posedge clk) begin
    a_d[0][0] <= a_w;
    a_d[0][1] <= a_x;
    a_d[0][2] <= a_y;
    a_d[0][3] <= a_z;
    a_d[1]    <= a_d[0];
    a_d[2]    <= a_d[1];
  end

  // Second product operands: t and the exact conjugate of a
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qa2[i] = {t[i][DW-1], t[i]};
    end
    qb2[0] = {a_d[2][0][DW-1], a_d[2][0]};
    for (int i = 1; i < 4; i++) begin
      qb2[i] = -{a_d[2][i][DW-1], a_d[2][i]};
    end
  end

  // Saturating conjugate for the conjugate opcode
  always_comb begin
    conj[0]  = a_d[2][0];
    conj_sat = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if (a_d[2][i] == MIND) begin
        conj[i]  = MAXD;
        conj_sat = 1'b1;
      end else begin
        conj[i] = -a_d[2][i];
      end
    end
  end

  qpr_mult #(.DATA_WIDTH(DATA_WIDTH)) u_mult2 (
    .clk(clk), .rst(rst), .in_ctrl(c3), .qa(qa2), .qb(qb2),
    .out_ctrl(c4), .prod(prod2)
  );

  qpr_accum #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_acc2 (
    .clk(clk), .rst(rst), .in_ctrl(c4), .prod(prod2),
    .out_ctrl(c6), .res(r2), .sat(f2)
  );

  // Side values held level with the second product
  always_ff @(posedge clk) begin
    s_t[0]    <= t;
    s_f1[0]   <= f1;
    s_conj[0] <= conj;
    s_cf[0]   <= conj_sat;
    for (int s = 1; s < 3; s++) begin
      s_t[s]    <= s_t[s-1];
      s_f1[s]   <= s_f1[s-1];
      s_conj[s] <= s_conj[s-1];
      s_cf[s]   <= s_cf[s-1];
    end
  end

  // Result select by opcode; the unused code gives all zeros
  always_comb begin
    case (c6.op)
      qpr_pkg::OP_PRODUCT: begin
        sel     = s_t[2];
        sel_sat = s_f1[2];
      end
      qpr_pkg::OP_ROTATE: begin
        sel[0]  = '0;
        sel[1]  = r2[1];
        sel[2]  = r2[2];
        sel[3]  = r2[3];
        sel_sat = s_f1[2] | f2;
      end
      qpr_pkg::OP_CONJ: begin
        sel     = s_conj[2];
        sel_sat = s_cf[2];
      end
      default: begin
        sel     = '{default: '0};
        sel_sat = 1'b0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    r_w       <= sel[0];
    r_x       <= sel[1];
    r_y       <= sel[2];
    r_z       <= sel[3];
    saturated <= sel_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c6.vld;
    end
  end

endmodule

FILE: sv/qpr_checker.sv
`include "quaternion_product_rotator_assert.svh"

// Port-level checks on the quaternion unit.
module qpr_checker #(
  parameter int DATA_WIDTH = qpr_pkg::DATA_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    opcode,
  input logic signed [DATA_WIDTH-1:0]  a_w,
  input logic                          done,
  input logic signed [DATA_WIDTH-1:0]  r_w
);

  logic acc;

  assign acc = start && !busy;

  // Every accepted word gives exactly one result at fixed latency
  `QPR_ASSERT_DELAY(a_accept_done, clk, rst, acc, qpr_pkg::LATENCY, done)
  `QPR_ASSERT_DELAY(a_idle_quiet, clk, rst, !acc, qpr_pkg::LATENCY, !done)

  // Rotation returns a pure vector
  `QPR_ASSERT_DELAY(a_rotate_w, clk, rst, acc && opcode == qpr_pkg::OP_ROTATE,
                    qpr_pkg::LATENCY, r_w == '0)

  // Conjugate passes the scalar part through untouched
  `QPR_ASSERT_DELAY(a_conj_w, clk, rst, acc && opcode == qpr_pkg::OP_CONJ,
                    qpr_pkg::LATENCY, r_w == $past(a_w, qpr_pkg::LATENCY))

endmodule

bind quaternion_product_rotator qpr_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qpr_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .a_w(a_w),
  .done(done), .r_w(r_w)
);
